### rtl/asrf_pkg.sv
package asrf_pkg;

  localparam int NUM_REGS = 58;
  localparam int PTR_W    = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS);
  localparam int DED_N    = 7;
  localparam int DED_W    = $clog2(DED_N);

  localparam logic [PTR_W-1:0] REG_ID      = 8'h00;
  localparam logic [PTR_W-1:0] REG_RATE    = 8'h2C;
  localparam logic [PTR_W-1:0] REG_INT_SRC = 8'h30;
  localparam logic [PTR_W-1:0] REG_FORMAT  = 8'h31;
  localparam logic [PTR_W-1:0] REG_LAST    = 8'h37;

  localparam logic [7:0] ID_RESET      = 8'hE5;
  localparam logic [7:0] RATE_RESET    = 8'h0A;
  localparam logic [7:0] INT_SRC_RESET = 8'h02;

  localparam logic [2:0] CMD_SPI    = 3'd0;
  localparam logic [2:0] CMD_I2C_WR = 3'd1;
  localparam logic [2:0] CMD_I2C_RD = 3'd2;
  localparam logic [2:0] CMD_SCALED = 3'd3;
  localparam logic [2:0] CMD_RAW    = 3'd4;

  localparam logic [7:0] IDX_FIRST  = 8'd1;
  localparam logic [7:0] IDX_SECOND = 8'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         byte_index;
    logic [7:0]         data_byte;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic [7:0] reset_value(logic [PTR_W-1:0] addr);
    logic [7:0] v;
    case (addr)
      REG_ID:      v = ID_RESET;
      REG_RATE:    v = RATE_RESET;
      REG_INT_SRC: v = INT_SRC_RESET;
      default:     v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/asrf_ctrl.sv
module asrf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  asrf_pkg::dp_status_t   status,
  output asrf_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   stall_r;

  assign cmd.capture = (state_r == S_IDLE) && in_valid && !stall_r;
  assign cmd.fetch   = (state_r == S_FETCH);
  assign cmd.exec    = (state_r == S_EXEC) && !status.out_busy;
  assign in_stall    = stall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && !stall_r) begin
            state_r <= S_FETCH;
            stall_r <= 1'b1;
          end
        end
        S_FETCH: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (!status.out_busy) begin
            state_r <= S_IDLE;
            stall_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/asrf_datapath.sv
module asrf_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  asrf_pkg::in_item_t    in_item,
  input  asrf_pkg::ctrl_cmd_t   cmd,
  input  logic                  out_stall,
  output logic                  out_valid,
  output asrf_pkg::out_item_t   out_item,
  output asrf_pkg::dp_status_t  status
);

  localparam int PW = asrf_pkg::PTR_W;
  localparam int AW = asrf_pkg::ADDR_W;

  asrf_pkg::in_item_t  item_r;
  asrf_pkg::out_item_t out_item_r;
  logic                out_valid_r;

  logic [PW-1:0] ptr_r, ptr_nxt, ptr_eff, ptr_inc;
  logic [1:0]    cmd_bits_r;

  logic [7:0]                   mem [0:asrf_pkg::NUM_REGS-1];
  logic [asrf_pkg::NUM_REGS-1:0] vld_r;
  logic [7:0]                   mem_q_r;
  logic                         vld_q_r;

  logic [7:0] ded_r [0:asrf_pkg::DED_N-1];

  logic                          eff_in_range, in_range, is_ded;
  logic [asrf_pkg::DED_W-1:0]    ded_idx;
  logic [PW-1:0]                 ded_off;
  logic                          spi_first, spi_act, rd_bit;
  logic                          do_read, do_wr, do_adv, wr_ok;
  logic [7:0]                    rd_byte;
  logic [1:0]                    code;
  logic [15:0]                   sx, sy, sz;

  function automatic logic [15:0] scale_axis(logic signed [15:0] v, logic [1:0] sh);
    logic signed [16:0] ext, bias, sum, shifted;
    ext     = {v[15], v};
    bias    = v[15] ? ((17'sd1 <<< sh) - 17'sd1) : 17'sd0;
    sum     = ext + bias;
    shifted = sum >>> sh;
    return shifted[15:0];
  endfunction

  // pointer as seen by the fetch step
  always_comb begin
    ptr_eff = ptr_r;
    if (item_r.cmd == asrf_pkg::CMD_SPI && item_r.byte_index == asrf_pkg::IDX_FIRST) begin
      ptr_eff = {2'b00, item_r.data_byte[5:0]};
    end else if (item_r.cmd == asrf_pkg::CMD_I2C_WR &&
                 item_r.byte_index == asrf_pkg::IDX_SECOND) begin
      ptr_eff = item_r.data_byte;
    end
  end

  assign eff_in_range = (ptr_eff < PW'(asrf_pkg::NUM_REGS));
  assign in_range     = (ptr_r < PW'(asrf_pkg::NUM_REGS));
  assign is_ded       = (ptr_r >= asrf_pkg::REG_FORMAT) && (ptr_r <= asrf_pkg::REG_LAST);
  assign ded_off      = ptr_r - asrf_pkg::REG_FORMAT;
  assign ded_idx      = ded_off[asrf_pkg::DED_W-1:0];

  assign spi_first = (item_r.cmd == asrf_pkg::CMD_SPI) &&
                     (item_r.byte_index == asrf_pkg::IDX_FIRST);
  assign spi_act   = (item_r.cmd == asrf_pkg::CMD_SPI) && !spi_first &&
                     ((item_r.byte_index == asrf_pkg::IDX_SECOND) || cmd_bits_r[0]);
  assign rd_bit    = cmd_bits_r[1];
  assign do_read   = ((spi_first || spi_act) && rd_bit) ||
                     (item_r.cmd == asrf_pkg::CMD_I2C_RD);
  assign do_wr     = (spi_act && !rd_bit) ||
                     ((item_r.cmd == asrf_pkg::CMD_I2C_WR) &&
                      (item_r.byte_index > asrf_pkg::IDX_SECOND));
  assign do_adv    = do_read || do_wr;
  assign wr_ok     = do_wr && in_range;

  always_comb begin
    if (!in_range) begin
      rd_byte = 8'h00;
    end else if (is_ded) begin
      rd_byte = ded_r[ded_idx];
    end else if (vld_q_r) begin
      rd_byte = mem_q_r;
    end else begin
      rd_byte = asrf_pkg::reset_value(ptr_r);
    end
  end

  assign ptr_inc = ptr_r + PW'(1);

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.fetch) begin
      ptr_nxt = ptr_eff;
    end else if (cmd.exec && do_adv) begin
      ptr_nxt = (ptr_inc >= PW'(asrf_pkg::NUM_REGS)) ?
                ptr_inc - PW'(asrf_pkg::NUM_REGS) : ptr_inc;
    end
  end

  // full resolution forces the finest range
  assign code = ded_r[0][3] ? 2'd0 : ded_r[0][1:0];
  assign sx   = scale_axis(item_r.accel_x, code);
  assign sy   = scale_axis(item_r.accel_y, code);
  assign sz   = scale_axis(item_r.accel_z, code);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.fetch && eff_in_range) begin
      mem_q_r <= mem[ptr_eff[AW-1:0]];
      vld_q_r <= vld_r[ptr_eff[AW-1:0]];
    end
    if (cmd.exec && wr_ok && !is_ded) begin
      mem[ptr_r[AW-1:0]] <= item_r.data_byte;
    end
    if (cmd.exec) begin
      out_item_r.read_data  <= do_read ? rd_byte : 8'h00;
      out_item_r.read_valid <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      cmd_bits_r  <= 2'b00;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < asrf_pkg::DED_N; i++) begin
        ded_r[i] <= 8'h00;
      end
    end else begin
      ptr_r <= ptr_nxt;
      if (cmd.fetch && spi_first) begin
        cmd_bits_r <= item_r.data_byte[7:6];
      end
      if (cmd.exec && wr_ok && !is_ded) begin
        vld_r[ptr_r[AW-1:0]] <= 1'b1;
      end
      if (cmd.exec && wr_ok && is_ded) begin
        ded_r[ded_idx] <= item_r.data_byte;
      end
      if (cmd.exec && item_r.cmd == asrf_pkg::CMD_SCALED) begin
        ded_r[1] <= sx[7:0];
        ded_r[2] <= sx[15:8];
        ded_r[3] <= sy[7:0];
        ded_r[4] <= sy[15:8];
        ded_r[5] <= sz[7:0];
        ded_r[6] <= sz[15:8];
      end
      if (cmd.exec && item_r.cmd == asrf_pkg::CMD_RAW) begin
        ded_r[1] <= item_r.accel_x[7:0];
        ded_r[2] <= item_r.accel_x[15:8];
        ded_r[3] <= item_r.accel_y[7:0];
        ded_r[4] <= item_r.accel_y[15:8];
        ded_r[5] <= item_r.accel_z[7:0];
        ded_r[6] <= item_r.accel_z[15:8];
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;
  assign status.out_busy = out_valid_r && out_stall;

  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && out_stall))
    else $error("result written over a waiting item");

  a_exec_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("result not presented after execute");

  a_no_data_without_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.read_valid) |-> (out_item_r.read_data == 8'h00))
    else $error("read data set without a read");

  a_fetch_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.fetch)
    else $error("fetch did not follow capture");

endmodule

### rtl/accel_sensor_register_file_core.sv
// register file of a three-axis accelerometer, one bus byte or sample load per item
// input channel: in_valid / in_stall with in_item (cmd, byte_index, data_byte,
//   accel_x/y/z); an item is taken when in_valid is high and in_stall is low
// result channel: out_valid / out_stall with out_item (read_data, read_valid);
//   every item gives exactly one result, read_valid low when no byte is returned
// sequence: the result is registered at the execute step, which follows the capture
//   and registered map read steps of the controller; a new item is taken only after
//   the current one has executed, as in_stall stays high from capture through execute
// reset: pointer and spi command bits clear, the map reads its reset values
//   (id, rate and interrupt source set, all else zero), no result pending
// stall: a waiting result holds on out_item; one more item is taken and runs
//   up to its execute step, where it waits until the result slot frees
module accel_sensor_register_file_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  asrf_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output asrf_pkg::out_item_t  out_item
);

  asrf_pkg::ctrl_cmd_t  cmd;
  asrf_pkg::dp_status_t status;

  asrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  asrf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .status    (status)
  );

endmodule
